FILE: rtl/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
// No dependencies; imported by every module of the block.
package mexp_pkg;

    localparam int BASE_BITS = 32;
    localparam int EXP_BITS  = 32;
    localparam int CFG_BITS  = 32;
    localparam int OUT_BITS  = 31;

    localparam logic [CFG_BITS-1:0] MOD_RESET = 32'h7FFF_FFFF;

    // job queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/mexp_queue.sv
// Short job queue between the front (base reduction) and the back (exponentiation).
// Depends on mexp_pkg for the status struct.
module mexp_queue #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output mexp_pkg::t_q_stat    o_stat
);
    import mexp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);

endmodule

FILE: rtl/mexp_front.sv
// Front end: modulus register, request intake, base reduction mod m (one bit a cycle).
// Depends on mexp_pkg; feeds mexp_queue.
module mexp_front #(
    parameter int MOD_BITS = 31,
    parameter int QW       = 2 * MOD_BITS + 34
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [mexp_pkg::CFG_BITS-1:0]  i_cfg_modulus,
    output logic                           o_cfg_ready,
    input  logic                           start,
    output logic                           busy,
    input  logic [mexp_pkg::BASE_BITS-1:0] i_base,
    input  logic [mexp_pkg::EXP_BITS-1:0]  i_exponent,
    input  mexp_pkg::t_q_stat              i_q_stat,
    output logic                           o_push,
    output logic [QW-1:0]                  o_job
);
    import mexp_pkg::*;

    localparam int MW = MOD_BITS + 1;
    localparam int CW = $clog2(BASE_BITS);
    localparam logic [CFG_BITS-1:0] LIM = CFG_BITS'(1) << MOD_BITS;
    localparam logic [CW-1:0] LAST_STEP = CW'(BASE_BITS - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RED  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                r_state, n_state;
    logic [CFG_BITS-1:0]    r_modulus;
    logic [MW-1:0]          r_m, n_m;
    logic [BASE_BITS-1:0]   r_b, n_b;
    logic [EXP_BITS-1:0]    r_e, n_e;
    logic [MOD_BITS-1:0]    r_r, n_r;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [MW-1:0]          m_eff;
    logic [MW-1:0]          shl;
    logic [MW-1:0]          shl_sub;
    logic                   m_is_one;

    // zero is taken as one, anything above 2^MOD_BITS saturates
    always_comb begin
        if (r_modulus == '0) begin
            m_eff = MW'(1);
        end else if (r_modulus > LIM) begin
            m_eff = MW'(LIM);
        end else begin
            m_eff = MW'(r_modulus);
        end
    end

    assign shl      = {r_r, r_b[BASE_BITS-1]};
    assign shl_sub  = shl - r_m;
    assign m_is_one = (r_m == MW'(1));

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_b     = r_b;
        n_e     = r_e;
        n_r     = r_r;
        n_cnt   = r_cnt;
        case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_m     = m_eff;
                    n_b     = i_base;
                    n_e     = i_exponent;
                    n_r     = '0;
                    n_cnt   = '0;
                    n_state = F_RED;
                end
            end
            F_RED: begin
                n_r   = (shl >= r_m) ? MOD_BITS'(shl_sub) : MOD_BITS'(shl);
                n_b   = r_b << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_modulus <= MOD_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_modulus <= i_cfg_modulus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_b   <= n_b;
        r_e   <= n_e;
        r_r   <= n_r;
        r_cnt <= n_cnt;
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != F_IDLE);
    assign o_push      = (r_state == F_PUSH) && !i_q_stat.full;
    // job layout: {modulus is one, exponent, modulus, reduced base}
    assign o_job       = {m_is_one, r_e, r_m, r_r};

endmodule

FILE: rtl/mexp_back.sv
// Back end: right-to-left square-and-multiply with one shared shift-add-reduce multiplier.
// Depends on mexp_pkg; pops jobs from mexp_queue and drives the result strobe.
module mexp_back #(
    parameter int MOD_BITS = 31,
    parameter int QW       = 2 * MOD_BITS + 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mexp_pkg::t_q_stat             i_q_stat,
    input  logic [QW-1:0]                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [mexp_pkg::OUT_BITS-1:0] o_power_mod
);
    import mexp_pkg::*;

    localparam int MW = MOD_BITS + 1;
    localparam int CW = $clog2(MOD_BITS);
    localparam logic [CW-1:0] LAST_STEP = CW'(MOD_BITS - 1);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_CHECK = 3'b010,
        B_MUL   = 3'b100
    } t_bstate;

    t_bstate              r_state, n_state;
    logic [MW-1:0]        r_m, n_m;
    logic [EXP_BITS-1:0]  r_e, n_e;
    logic [MOD_BITS-1:0]  r_res, n_res;
    logic [MOD_BITS-1:0]  r_sq, n_sq;
    logic                 r_did_res, n_did_res;
    logic                 r_tgt_res, n_tgt_res;
    logic [MOD_BITS-1:0]  r_acc, n_acc;
    logic [MOD_BITS-1:0]  r_x, n_x;
    logic [MOD_BITS-1:0]  r_y, n_y;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_valid, n_valid;
    logic [MOD_BITS-1:0]  r_out, n_out;

    logic                 job_one;
    logic [EXP_BITS-1:0]  job_e;
    logic [MW-1:0]        job_m;
    logic [MOD_BITS-1:0]  job_sq;
    logic [MW-1:0]        add_sum, add_sub, dbl, dbl_sub;
    logic [MOD_BITS-1:0]  acc_nx, y_nx;

    assign {job_one, job_e, job_m, job_sq} = i_job;

    // one multiplier step: acc += x[i] ? y : 0, y *= 2, both reduced mod m
    assign add_sum = {1'b0, r_acc} + (r_x[0] ? {1'b0, r_y} : '0);
    assign add_sub = add_sum - r_m;
    assign acc_nx  = (add_sum >= r_m) ? MOD_BITS'(add_sub) : MOD_BITS'(add_sum);
    assign dbl     = {r_y, 1'b0};
    assign dbl_sub = dbl - r_m;
    assign y_nx    = (dbl >= r_m) ? MOD_BITS'(dbl_sub) : MOD_BITS'(dbl);

    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_e       = r_e;
        n_res     = r_res;
        n_sq      = r_sq;
        n_did_res = r_did_res;
        n_tgt_res = r_tgt_res;
        n_acc     = r_acc;
        n_x       = r_x;
        n_y       = r_y;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_out     = r_out;
        o_pop     = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop     = 1'b1;
                    n_m       = job_m;
                    n_e       = job_e;
                    n_sq      = job_sq;
                    n_res     = job_one ? '0 : MOD_BITS'(1);
                    n_did_res = 1'b0;
                    n_state   = B_CHECK;
                end
            end
            B_CHECK: begin
                n_acc = '0;
                n_cnt = '0;
                if (r_e == '0) begin
                    n_valid = 1'b1;
                    n_out   = r_res;
                    n_state = B_IDLE;
                end else if (r_e[0] && !r_did_res) begin
                    n_x       = r_res;
                    n_y       = r_sq;
                    n_tgt_res = 1'b1;
                    n_state   = B_MUL;
                end else begin
                    n_x       = r_sq;
                    n_y       = r_sq;
                    n_tgt_res = 1'b0;
                    n_state   = B_MUL;
                end
            end
            B_MUL: begin
                n_acc = acc_nx;
                n_y   = y_nx;
                n_x   = r_x >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    if (r_tgt_res) begin
                        n_res     = acc_nx;
                        n_did_res = 1'b1;
                    end else begin
                        n_sq      = acc_nx;
                        n_e       = r_e >> 1;
                        n_did_res = 1'b0;
                    end
                    n_state = B_CHECK;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_e       <= n_e;
        r_res     <= n_res;
        r_sq      <= n_sq;
        r_did_res <= n_did_res;
        r_tgt_res <= n_tgt_res;
        r_acc     <= n_acc;
        r_x       <= n_x;
        r_y       <= n_y;
        r_cnt     <= n_cnt;
        r_out     <= n_out;
    end

    assign o_valid     = r_valid;
    assign o_power_mod = OUT_BITS'(r_out);

endmodule

FILE: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: base^exponent mod modulus.
// Depends on mexp_pkg, mexp_front, mexp_queue, mexp_back.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------
//  request   | start in, busy out         | i_base, i_exponent
//  config    | i_cfg_valid, o_cfg_ready   | i_cfg_modulus
//  result    | o_valid strobe, one cycle  | o_power_mod
//
// The front takes a request when start is high and busy low, and reduces the base
// mod m one bit a cycle; it then hands the job to a 2-entry queue.
// The back does one modular multiply per set exponent bit plus one square per
// exponent bit up to the top set bit, all on its one shared multiplier.
// busy is high while the front reduces the base and pushes the job, and stays high
// while the queue is full.
// Reset is synchronous, active low; the modulus resets to 2^31-1. Results cannot stall.
module modular_exponentiation #(
    parameter int MOD_BITS = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [mexp_pkg::CFG_BITS-1:0]  i_cfg_modulus,
    output logic                           o_cfg_ready,
    input  logic                           start,
    output logic                           busy,
    input  logic [mexp_pkg::BASE_BITS-1:0] i_base,
    input  logic [mexp_pkg::EXP_BITS-1:0]  i_exponent,
    output logic                           o_valid,
    output logic [mexp_pkg::OUT_BITS-1:0]  o_power_mod
);
    import mexp_pkg::*;

    localparam int QW = 1 + EXP_BITS + (MOD_BITS + 1) + MOD_BITS;

    t_q_stat         q_stat;
    logic            push, pop;
    logic [QW-1:0]   job_in, job_out;

    mexp_front #(
        .MOD_BITS (MOD_BITS),
        .QW       (QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_modulus (i_cfg_modulus),
        .o_cfg_ready   (o_cfg_ready),
        .start         (start),
        .busy          (busy),
        .i_base        (i_base),
        .i_exponent    (i_exponent),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_job         (job_in)
    );

    mexp_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_stat  (q_stat)
    );

    mexp_back #(
        .MOD_BITS (MOD_BITS),
        .QW       (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_power_mod (o_power_mod)
    );

endmodule

FILE: rtl/mexp_chk.sv
// Port-level checker for modular_exponentiation, bound to the top level.
// Depends on mexp_pkg for port widths.
module mexp_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_valid,
    input logic [mexp_pkg::CFG_BITS-1:0]  i_cfg_modulus,
    input logic                           o_cfg_ready,
    input logic                           start,
    input logic                           busy,
    input logic [mexp_pkg::BASE_BITS-1:0] i_base,
    input logic [mexp_pkg::EXP_BITS-1:0]  i_exponent,
    input logic                           o_valid,
    input logic [mexp_pkg::OUT_BITS-1:0]  o_power_mod
);
    import mexp_pkg::*;

    logic [2:0] r_pend;
    logic       accept;

    assign accept = start && !busy;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {2'b00, accept} - {2'b00, o_valid};
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after a request was taken");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!busy && !o_valid))
        else $error("block not idle after reset");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != '0))
        else $error("result with no request outstanding");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (.*);
